[design/llsp_pkg.sv]
// llsp_pkg: word types, controller states and control/status bundles
// for the least-loaded slot picker. No dependencies.
`default_nettype none

package llsp_pkg;

    localparam int QUEUE_W = 16;
    localparam int DRAW_W  = 16;
    localparam int INDEX_W = 4;

    typedef struct packed {
        logic               slot_active;
        logic [QUEUE_W-1:0] queued_tuples;
        logic [DRAW_W-1:0]  random_draw;
        logic               last_location;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic               took_free_slot;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TIE,
        ST_DIV,
        ST_SEL,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // store one location
        logic walk_start;  // rewind the table walk
        logic walk_run;    // advance the table walk
        logic sel_mode;    // walk picks a candidate instead of counting ties
        logic div_start;   // load divisor and draw into the remainder unit
        logic div_run;     // one remainder step
        logic emit;        // register the result and clear the set
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic free_any;    // at least one stored slot is free
        logic walk_done;   // every stored entry has been examined
        logic hit;         // selection walk found the target candidate
        logic div_last;    // final remainder step in progress
    } sts_t;

endpackage

`default_nettype wire

[design/least_loaded_slot_picker.sv]
// least_loaded_slot_picker: top level, joins the controller and datapath.
// Depends on llsp_pkg, llsp_ctrl, llsp_dpath (and through it llsp_ram).
//
//  channel | ports                 | handshake
//  --------+-----------------------+----------------------------------------
//  in      | in_word (in_word_t)   | word taken on clk rise with start & !busy
//  out     | result (out_word_t)   | word valid for the one cycle done is high
//
// Flow: each non-final location word is taken while busy stays low, so a set
// streams in at one word per cycle. After the last word busy rises through a
// check state, a walk counting ties on the minimum queue (skipped when a free
// slot exists), the one-bit-per-cycle remainder unit, the selection walk over
// the stored locations (at most MAX_LOCATIONS) in the queue RAM (one read
// port), and an emit state; done follows in the cycle busy drops. Reset clears
// the set (no free slots, minimum all ones, no stored locations); queue RAM
// contents are not cleared. The receiver cannot stall: a result is shown once
// and is gone.
`default_nettype none

module least_loaded_slot_picker #(
    parameter int MAX_LOCATIONS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire llsp_pkg::in_word_t in_word,
    output logic                    done,
    output llsp_pkg::out_word_t     result
);

    import llsp_pkg::*;

    cmd_t cmd;  // sequencing commands to the datapath
    sts_t sts;  // walk / divider / free-slot status back to the controller

    // controller: sequences load, tie count, remainder and selection
    llsp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (in_word.last_location),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: location table, walk, remainder unit, result register
    llsp_dpath #(
        .MAX_LOCATIONS (MAX_LOCATIONS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_word),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

[design/llsp_ram.sv]
// llsp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module llsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/llsp_ctrl.sv]
// llsp_ctrl: sequencing state machine of the slot picker.
// Depends on llsp_pkg.
`default_nettype none

module llsp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          last,
    input  wire llsp_pkg::sts_t sts,
    output llsp_pkg::cmd_t     cmd,
    output logic               busy
);

    import llsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.free_any ? ST_DIV : ST_TIE;
            end
            ST_TIE:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                if (sts.hit || sts.walk_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_CHECK:
            begin
                cmd.div_start  = sts.free_any;
                cmd.walk_start = !sts.free_any;
            end
            ST_TIE:
            begin
                cmd.walk_run  = 1'b1;
                cmd.div_start = sts.walk_done;
            end
            ST_DIV:
            begin
                cmd.div_run    = 1'b1;
                cmd.walk_start = sts.div_last;
            end
            ST_SEL:
            begin
                cmd.walk_run = 1'b1;
                cmd.sel_mode = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/llsp_dpath.sv]
// llsp_dpath: location table, running minimum, free count, table walk,
// bit-serial remainder unit and result register. Depends on llsp_pkg, llsp_ram.
`default_nettype none

module llsp_dpath #(
    parameter int MAX_LOCATIONS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire llsp_pkg::in_word_t in_word,
    input  wire llsp_pkg::cmd_t     cmd,
    output llsp_pkg::sts_t          sts,
    output logic                    done,
    output llsp_pkg::out_word_t     result
);

    import llsp_pkg::*;

    localparam int IDX_W  = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_LOCATIONS + 1);
    localparam int STEP_W = $clog2(DRAW_W);
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_LOCATIONS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DRAW_W - 1);

    // set state
    logic [MAX_LOCATIONS-1:0] free_mask_reg;
    logic [QUEUE_W-1:0]       min_queue_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         free_cnt_reg;
    logic [DRAW_W-1:0]        draw_reg;

    // walk
    logic [CNT_W-1:0] ptr_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] tie_cnt_reg;
    logic [CNT_W-1:0] seen_reg;
    logic [IDX_W-1:0] chosen_reg;

    // remainder unit
    logic [CNT_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;

    logic              done_reg;
    out_word_t         result_reg;

    logic              store;
    logic [QUEUE_W-1:0] rd_queue;
    logic              issue;
    logic              cand;
    logic              hit;
    logic [CNT_W:0]    trial;
    logic [CNT_W-1:0]  rem_next;

    assign store = cmd.load && (count_reg < MAX_CNT);
    assign issue = cmd.walk_run && (ptr_reg < count_reg);

    llsp_ram #(
        .WIDTH (QUEUE_W),
        .DEPTH (MAX_LOCATIONS)
    ) u_queue_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_word.queued_tuples),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (rd_queue)
    );

    // candidate: a free slot when any exists, otherwise an active slot on the minimum
    always_comb
    begin
        if (free_cnt_reg != '0)
        begin
            cand = free_mask_reg[rd_idx_reg];
        end
        else
        begin
            cand = !free_mask_reg[rd_idx_reg] && (rd_queue == min_queue_reg);
        end
    end

    assign hit = cmd.sel_mode && rd_vld_reg && cand && (seen_reg == rem_reg);

    always_comb
    begin
        trial = {rem_reg, draw_reg[DRAW_W-1]};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_next = CNT_W'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_mask_reg <= '0;
            min_queue_reg <= '1;
            count_reg     <= '0;
            free_cnt_reg  <= '0;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.emit)
            begin
                free_mask_reg <= '0;
                min_queue_reg <= '1;
                count_reg     <= '0;
                free_cnt_reg  <= '0;
            end
            else if (store)
            begin
                free_mask_reg[count_reg[IDX_W-1:0]] <= !in_word.slot_active;
                if (in_word.slot_active && (in_word.queued_tuples < min_queue_reg))
                begin
                    min_queue_reg <= in_word.queued_tuples;
                end
                if (!in_word.slot_active)
                begin
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                end
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.walk_start)
            begin
                ptr_reg    <= '0;
                rd_vld_reg <= 1'b0;
            end
            else if (cmd.walk_run)
            begin
                rd_vld_reg <= issue;
                if (issue)
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end

            if (cmd.div_start)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_run)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && in_word.last_location)
        begin
            draw_reg <= in_word.random_draw;
        end
        else if (cmd.div_run)
        begin
            draw_reg <= {draw_reg[DRAW_W-2:0], 1'b0};
        end

        if (issue)
        begin
            rd_idx_reg <= ptr_reg[IDX_W-1:0];
        end

        if (cmd.walk_start)
        begin
            tie_cnt_reg <= '0;
            seen_reg    <= '0;
            chosen_reg  <= '0;
        end
        else if (cmd.walk_run && rd_vld_reg && cand)
        begin
            if (!cmd.sel_mode)
            begin
                tie_cnt_reg <= tie_cnt_reg + 1'b1;
            end
            else if (hit)
            begin
                chosen_reg <= rd_idx_reg;
            end
            else
            begin
                seen_reg <= seen_reg + 1'b1;
            end
        end

        if (cmd.div_start)
        begin
            divisor_reg <= (free_cnt_reg != '0) ? free_cnt_reg : tie_cnt_reg;
            rem_reg     <= '0;
        end
        else if (cmd.div_run)
        begin
            rem_reg <= rem_next;
        end

        if (cmd.emit)
        begin
            result_reg.chosen_index   <= INDEX_W'(chosen_reg);
            result_reg.took_free_slot <= (free_cnt_reg != '0);
        end
    end

    assign sts.free_any  = (free_cnt_reg != '0);
    assign sts.walk_done = (ptr_reg == count_reg) && !rd_vld_reg;
    assign sts.hit       = hit;
    assign sts.div_last  = (step_reg == LAST_STEP);

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[design/llsp_checker.sv]
// llsp_checker: port-level assertions for least_loaded_slot_picker, bound
// to the top level below. Depends on llsp_pkg.
`default_nettype none

module llsp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire llsp_pkg::in_word_t in_word,
    input wire logic               done
);

    // a final word always starts the selection
    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && in_word.last_location |=> busy)
        else $error("last word did not start selection");

    // other words are absorbed without raising busy or done
    a_mid_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !in_word.last_location |=> !busy && !done)
        else $error("non-final word blocked input or produced a result");

    // result strobe is never back to back
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

    // result shows up as selection completes
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result outside end of selection");

endmodule

bind least_loaded_slot_picker llsp_checker u_llsp_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .done    (done)
);

`default_nettype wire
